### design/smhe_pkg.sv
package smhe_pkg;

    localparam int SWEEP_HISTORY = 4;
    localparam int CHANNEL_COUNT = 16;

    localparam int SAMPLE_W  = 10;
    localparam int RSSI_W    = 8;
    localparam int CHAN_W    = 4;
    localparam int ENERGY_W  = 9;
    localparam int QUOT_W    = 6;

    localparam int STORE_DEPTH = SWEEP_HISTORY * CHANNEL_COUNT;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SLOT_W = (SWEEP_HISTORY > 1) ? $clog2(SWEEP_HISTORY) : 1;
    localparam int SCH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam logic signed [RSSI_W-1:0] OFFSET_RESET = 8'sd53;

    // x / 20 as x * 205 >> 12, exact for |x| <= 256
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 12;
    localparam int MAG_W       = SAMPLE_W - 1;
    localparam int PROD_W      = MAG_W + 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    function automatic logic signed [QUOT_W-1:0] div20(input logic signed [SAMPLE_W-1:0] x);
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] q;
        neg  = x[SAMPLE_W-1];
        mag  = neg ? MAG_W'(-x) : MAG_W'(x);
        prod = PROD_W'(mag) * PROD_W'(RECIP_MUL);
        q    = QUOT_W'(prod >> RECIP_SHIFT);
        return neg ? -$signed(q) : $signed(q);
    endfunction

endpackage

### design/spectrum_max_hold_energy_unit.sv
// Spectrum max-hold energy unit. One transaction on the s_axis side carries one channel
// reading; reading plus rssi_offset is written into a 64-entry history store (4 sweeps x
// 16 channels, zero after reset). A reading for any channel but the last is accepted while
// the unit is idle. The reading for the last channel advances the sweep slot and starts a
// walk over the store, one entry per cycle through its single read port, taking each
// channel's maximum, dividing it by 20 (truncated toward zero) and summing. The sum leaves as
// one m_axis transaction once the walk has drained through the read, peak, quotient and
// result registers. Input is held off during the walk and while a second score waits for
// an untaken first one.
module spectrum_max_hold_energy_unit
    import smhe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // rssi_offset
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [3:0] chan_index, [11:4] rssi_raw, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [8:0] energy_total, rest zero
);

    t_state r_state, n_state;

    logic signed [RSSI_W-1:0]   r_offset;
    logic [SLOT_W-1:0]          r_wr_slot;

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]     r_valid;

    logic [CHAN_W-1:0]          s_chan;
    logic signed [RSSI_W-1:0]   s_raw;
    logic                       in_xact, chan_ok, chan_last;
    logic [ADDR_W-1:0]          wr_addr, rd_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    logic [SLOT_W-1:0]          r_scan_slot;
    logic [SCH_W-1:0]           r_scan_ch;
    logic                       scan_slot_last, scan_ch_last;

    logic                       r_rd_en, r_rd_first, r_rd_last, r_rd_ch_last, r_rd_hit;
    logic signed [SAMPLE_W-1:0] r_rd_data, rd_val;
    logic signed [SAMPLE_W-1:0] r_peak, n_peak, r_pk;
    logic                       r_pk_vld, r_pk_last;
    logic signed [QUOT_W-1:0]   r_q;
    logic                       r_q_vld, r_q_last;
    logic signed [ENERGY_W-1:0] r_total, sum_next, r_res;

    logic                       issue, out_load, out_free;

    assign s_chan    = s_axis_tdata[3:0];
    assign s_raw     = s_axis_tdata[11:4];
    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign chan_ok   = {1'b0, s_chan} < 5'(CHANNEL_COUNT);
    assign chan_last = s_chan == CHAN_W'(CHANNEL_COUNT - 1);
    assign wr_addr   = ADDR_W'(ADDR_W'(r_wr_slot) * ADDR_W'(CHANNEL_COUNT) + ADDR_W'(s_chan));
    assign wr_data   = SAMPLE_W'(s_raw) + SAMPLE_W'(r_offset);
    assign rd_addr   = ADDR_W'(ADDR_W'(r_scan_slot) * ADDR_W'(CHANNEL_COUNT)
                       + ADDR_W'(r_scan_ch));

    assign scan_slot_last = r_scan_slot == SLOT_W'(SWEEP_HISTORY - 1);
    assign scan_ch_last   = r_scan_ch == SCH_W'(CHANNEL_COUNT - 1);
    assign out_free       = !m_axis_tvalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_xact && chan_ok && chan_last) n_state = ST_SCAN;
            ST_SCAN:  if (scan_slot_last && scan_ch_last) n_state = ST_DRAIN;
            ST_DRAIN: if (r_q_vld && r_q_last) n_state = ST_EMIT;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SCAN:  issue = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  out_load = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    // history store, entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (in_xact && chan_ok) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_wr_slot <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            r_rd_hit <= r_valid[rd_addr];
            if (in_xact && chan_ok) begin
                r_valid[wr_addr] <= 1'b1;
                if (chan_last) begin
                    r_wr_slot <= (r_wr_slot == SLOT_W'(SWEEP_HISTORY - 1))
                                 ? '0 : r_wr_slot + SLOT_W'(1);
                end
            end
        end
    end

    // walk: channel outer, slot inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_slot <= '0;
            r_scan_ch   <= '0;
        end else if (issue) begin
            if (scan_slot_last) begin
                r_scan_slot <= '0;
                r_scan_ch   <= scan_ch_last ? '0 : r_scan_ch + SCH_W'(1);
            end else begin
                r_scan_slot <= r_scan_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= issue;
        end
        r_rd_first   <= r_scan_slot == '0;
        r_rd_last    <= scan_slot_last;
        r_rd_ch_last <= scan_ch_last;
    end

    assign rd_val = r_rd_hit ? r_rd_data : '0;
    assign n_peak = (r_rd_first || rd_val > r_peak) ? rd_val : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_vld <= 1'b0;
            r_q_vld  <= 1'b0;
        end else begin
            r_pk_vld <= r_rd_en && r_rd_last;
            r_q_vld  <= r_pk_vld;
        end
        if (r_rd_en) begin
            r_peak <= n_peak;
        end
        if (r_rd_en && r_rd_last) begin
            r_pk      <= n_peak;
            r_pk_last <= r_rd_ch_last;
        end
        if (r_pk_vld) begin
            r_q      <= div20(r_pk);
            r_q_last <= r_pk_last;
        end
    end

    assign sum_next = r_total + ENERGY_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_total <= '0;
        end else if (r_q_vld) begin
            r_total <= sum_next;
        end
        if (r_q_vld && r_q_last) begin
            r_res <= sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
        if (out_load) begin
            m_axis_tdata <= {(16 - ENERGY_W)'(0), r_res};
        end
    end

`ifndef NO_ASSERTIONS
    a_sweep_end_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xact && chan_ok && chan_last) |=> r_state == ST_SCAN)
        else $error("sweep end did not start scan");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_en && !r_pk_vld && !r_q_vld))
        else $error("score pipeline busy while idle");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_EMIT)
        else $error("result raised outside emit");
`endif

endmodule
